[src/dlpg_pkg.sv]
package dlpg_pkg;

    localparam int COORD_BITS  = 8;
    localparam int SAMPLE_GAP  = 6;
    localparam int FIELD_BITS  = 8;
    // error term spans -2*major .. 2*minor, two bits above the coordinate
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int CNT_BITS    = $clog2(SAMPLE_GAP + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [FIELD_BITS-1:0] x_start;
        logic [FIELD_BITS-1:0] y_start;
        logic [FIELD_BITS-1:0] x_end;
        logic [FIELD_BITS-1:0] y_end;
    } in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] point_x;
        logic [FIELD_BITS-1:0] point_y;
        logic                  last;
    } out_t;

    // one classified line, ready for the walker
    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] major;
        logic [ERR_BITS-1:0]   e0;
        logic [ERR_BITS-1:0]   inc_move;
        logic [ERR_BITS-1:0]   inc_stay;
        logic                  y_major;
        logic                  x_neg;
        logic                  y_neg;
    } job_t;

endpackage

[src/dlpg_front.sv]
module dlpg_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dlpg_pkg::in_t  s_data,
    output logic           push_valid,
    input  logic           push_ready,
    output dlpg_pkg::job_t push_data
);
    import dlpg_pkg::*;

    logic                  in_valid_reg;
    in_t                   in_reg;
    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  y_major;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic [ERR_BITS-1:0]   two_minor;
    logic [ERR_BITS-1:0]   two_major;

    assign s_ready    = !in_valid_reg || push_ready;
    assign push_valid = in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_comb begin
        dx = {1'b0, in_reg.x_end[COORD_BITS-1:0]} - {1'b0, in_reg.x_start[COORD_BITS-1:0]};
        dy = {1'b0, in_reg.y_end[COORD_BITS-1:0]} - {1'b0, in_reg.y_start[COORD_BITS-1:0]};
        adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        // ties stay on x
        y_major   = ady > adx;
        major     = y_major ? ady : adx;
        minor     = y_major ? adx : ady;
        two_minor = ERR_BITS'({minor, 1'b0});
        two_major = ERR_BITS'({major, 1'b0});

        push_data.x0       = in_reg.x_start[COORD_BITS-1:0];
        push_data.y0       = in_reg.y_start[COORD_BITS-1:0];
        push_data.major    = major;
        push_data.e0       = two_minor - ERR_BITS'(major);
        push_data.inc_move = two_minor - two_major;
        push_data.inc_stay = two_minor;
        push_data.y_major  = y_major;
        push_data.x_neg    = dx[COORD_BITS];
        push_data.y_neg    = dy[COORD_BITS];
    end

endmodule

[src/dlpg_queue.sv]
module dlpg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  dlpg_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output dlpg_pkg::job_t pop_data
);
    import dlpg_pkg::*;

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

[src/dlpg_back.sv]
module dlpg_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  dlpg_pkg::job_t pop_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dlpg_pkg::out_t m_data
);
    import dlpg_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    job_t                  job_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] x_next;
    logic [COORD_BITS-1:0] y_reg;
    logic [COORD_BITS-1:0] y_next;
    logic [ERR_BITS-1:0]   e_reg;
    logic [ERR_BITS-1:0]   e_next;
    logic [COORD_BITS-1:0] rem_reg;
    logic [COORD_BITS-1:0] rem_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [CNT_BITS-1:0]   cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_t                  out_reg;
    out_t                  out_next;
    logic                  out_free;
    logic                  sample;
    logic                  move_minor;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;

    assign out_free   = !out_valid_reg || m_ready;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;
    assign pop_ready  = state_reg == ST_IDLE;
    assign sample     = cnt_reg == CNT_BITS'(SAMPLE_GAP);
    assign move_minor = !e_reg[ERR_BITS-1];
    assign step_x     = job_reg.x_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
    assign step_y     = job_reg.y_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        e_next         = e_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    x_next     = pop_data.x0;
                    y_next     = pop_data.y0;
                    e_next     = pop_data.e0;
                    rem_next   = pop_data.major;
                    cnt_next   = '0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_next.point_x = FIELD_BITS'(x_reg);
                    out_next.point_y = FIELD_BITS'(y_reg);
                    out_next.last    = 1'b0;
                    state_next = (rem_reg == '0) ? ST_END : ST_WALK;
                end
            end
            ST_WALK: begin
                // a sample step waits for room in the output register
                if (!sample || out_free) begin
                    if (sample) begin
                        out_valid_next   = 1'b1;
                        out_next.point_x = FIELD_BITS'(x_reg);
                        out_next.point_y = FIELD_BITS'(y_reg);
                        out_next.last    = 1'b0;
                        cnt_next         = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (!job_reg.y_major || move_minor) begin
                        x_next = x_reg + step_x;
                    end
                    if (job_reg.y_major || move_minor) begin
                        y_next = y_reg + step_y;
                    end
                    e_next   = e_reg + (move_minor ? job_reg.inc_move : job_reg.inc_stay);
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == COORD_BITS'(1)) begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_next.point_x = FIELD_BITS'(x_reg);
                    out_next.point_y = FIELD_BITS'(y_reg);
                    out_next.last    = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && pop_valid) begin
            job_reg <= pop_data;
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        e_reg   <= e_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
    end

    a_walk_has_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> rem_reg != '0)
        else $error("walk state with no steps left");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> cnt_reg <= CNT_BITS'(SAMPLE_GAP))
        else $error("sample counter past gap");

    a_end_emits_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_END && out_free) |=> (out_valid_reg && out_reg.last
            && state_reg == ST_IDLE))
        else $error("end point not loaded as last");

endmodule

[src/decimated_line_point_generator.sv]
// Line point generator: each input transfer carries two endpoints; the block walks the
// line with Bresenham stepping along its major axis and returns the start point, one
// sampled point every SAMPLE_GAP+1 steps, and finally the end point with last set
// (a zero-length line returns the start point twice). A setup stage classifies the
// line and hands it through a two-entry queue to the walker, which takes one step per
// cycle while the result side does not hold off the start point, a sample or the end
// point; a line takes major steps, where major is the larger of |dx| and |dy|, and the
// walker takes the next line from the queue only after the end point of the last one.
// Input bits above COORD_BITS are ignored.
module decimated_line_point_generator (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dlpg_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dlpg_pkg::out_t m_data
);
    import dlpg_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    dlpg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dlpg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    dlpg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
